FILE: rtl/core/u8sd_pkg.sv
// u8sd_pkg: shared types, tables and codes for the UTF-8 stream decoder.
// No dependencies; used by every module under rtl/core.
package u8sd_pkg;

	localparam int unsigned AccW  = 21;
	localparam int unsigned StW   = 4;
	localparam int unsigned CatW  = 4;
	localparam int unsigned StatW = 2;

	localparam logic [StW-1:0] STATE_ACCEPT = 4'd0;
	localparam logic [StW-1:0] STATE_REJECT = 4'd8;

	localparam logic [StatW-1:0] STATUS_COMPLETE = 2'd0;
	localparam logic [StatW-1:0] STATUS_PENDING  = 2'd1;
	localparam logic [StatW-1:0] STATUS_REJECTED = 2'd2;

	// byte category for 0x80..0xFF: word byte[6:3], nibble byte[2:0]
	localparam logic [31:0] CLASS_WORDS [16] = '{
		32'h11111111, 32'h11111111, 32'h77777777, 32'h77777777,
		32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888,
		32'h22222299, 32'h22222222, 32'h22222222, 32'h22222222,
		32'h3333333a, 32'h33433333, 32'h9995666b, 32'h99999999
	};

	// next state: word per category, nibble per current state 0..7
	localparam logic [31:0] NEXT_WORDS [16] = '{
		32'h88888880, 32'h22818108, 32'h88888881, 32'h88888882,
		32'h88888884, 32'h88888887, 32'h88888886, 32'h82218108,
		32'h82281108, 32'h88888888, 32'h88888883, 32'h88888885,
		32'h88888888, 32'h88888888, 32'h88888888, 32'h88888888
	};

	typedef struct packed {
		logic [7:0] byte_in;
		logic       restart;
	} in_word_t;

	typedef struct packed {
		logic [AccW-1:0]  code_point;
		logic [StatW-1:0] status;
	} out_word_t;

	typedef struct packed {
		logic [StW-1:0]   state;
		logic [AccW-1:0]  acc;
		logic [StatW-1:0] status;
	} dec_next_t;

endpackage

FILE: rtl/core/u8sd_classify.sv
// u8sd_classify: maps a raw byte to its UTF-8 category.
// Depends on u8sd_pkg (CLASS_WORDS).
module u8sd_classify (
	input  logic [7:0]                 byte_in,
	output logic [u8sd_pkg::CatW-1:0]  category
);

	logic [31:0] word;

	always_comb begin
		word = u8sd_pkg::CLASS_WORDS[byte_in[6:3]];
		if (!byte_in[7]) begin
			category = '0;
		end else begin
			category = word[{byte_in[2:0], 2'b00} +: 4];
		end
	end

endmodule

FILE: rtl/core/u8sd_step.sv
// u8sd_step: one decoder transition: next state, accumulator and status.
// Depends on u8sd_pkg (NEXT_WORDS, state and status codes, dec_next_t).
module u8sd_step (
	input  logic [u8sd_pkg::StW-1:0]  cur_state,
	input  logic [u8sd_pkg::AccW-1:0] cur_acc,
	input  logic [u8sd_pkg::CatW-1:0] category,
	input  logic [7:0]                byte_in,
	output u8sd_pkg::dec_next_t       nxt
);

	logic [31:0] word;
	logic [7:0]  lead_mask;

	always_comb begin
		word      = u8sd_pkg::NEXT_WORDS[category];
		lead_mask = 8'hff >> category;

		if (cur_state != u8sd_pkg::STATE_ACCEPT) begin
			nxt.acc = {cur_acc[u8sd_pkg::AccW-7:0], byte_in[5:0]};
		end else begin
			nxt.acc = {{(u8sd_pkg::AccW-8){1'b0}}, lead_mask & byte_in};
		end

		if (cur_state[3]) begin
			nxt.state = u8sd_pkg::STATE_REJECT;
		end else begin
			nxt.state = word[{cur_state[2:0], 2'b00} +: 4];
		end

		if (nxt.state == u8sd_pkg::STATE_ACCEPT) begin
			nxt.status = u8sd_pkg::STATUS_COMPLETE;
		end else if (nxt.state[3]) begin
			nxt.status = u8sd_pkg::STATUS_REJECTED;
		end else begin
			nxt.status = u8sd_pkg::STATUS_PENDING;
		end
	end

endmodule

FILE: rtl/core/utf8_stream_decoder.sv
// utf8_stream_decoder: validating UTF-8 decoder, one byte per word.
// Depends on u8sd_pkg, u8sd_classify and u8sd_step.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_word  (byte_in, restart)
//   out      out_valid/out_ready  out_word (code_point, status)
//
// One word per cycle sustained while out_ready is high: input register,
// then the table lookups and accumulator shift feed the result register.
// Decode state and accumulator update when a word moves into the result
// register. Reset puts the decoder in the accept state with a zero
// accumulator. A stalled output holds the input register; in_ready drops
// only when both registers are full and out_ready is low.
module utf8_stream_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  u8sd_pkg::in_word_t    in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output u8sd_pkg::out_word_t   out_word
);

	u8sd_pkg::in_word_t            word_s1;
	logic                          valid_s1;
	logic [u8sd_pkg::StW-1:0]      state_q;
	logic [u8sd_pkg::AccW-1:0]     acc_q;
	u8sd_pkg::out_word_t           out_q;
	logic                          out_valid_q;

	logic                          advance;
	logic [u8sd_pkg::StW-1:0]      cur_state;
	logic [u8sd_pkg::CatW-1:0]     category;
	u8sd_pkg::dec_next_t           nxt;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cur_state = word_s1.restart ? u8sd_pkg::STATE_ACCEPT : state_q;

	u8sd_classify u_classify (
		.byte_in  (word_s1.byte_in),
		.category (category)
	);

	u8sd_step u_step (
		.cur_state (cur_state),
		.cur_acc   (acc_q),
		.category  (category),
		.byte_in   (word_s1.byte_in),
		.nxt       (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= u8sd_pkg::STATE_ACCEPT;
			acc_q       <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= nxt.state;
				acc_q       <= nxt.acc;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
		if (advance) begin
			out_q.code_point <= nxt.acc;
			out_q.status     <= nxt.status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
